>>> rtl/core/filtered_position_velocity_accel_top_macros.svh
// Assertion macros shared by the checker of the filtered position estimator.
`ifndef FILTERED_POSITION_VELOCITY_ACCEL_TOP_MACROS_SVH
`define FILTERED_POSITION_VELOCITY_ACCEL_TOP_MACROS_SVH
// An antecedent must be followed by the consequent in the next cycle.
`define FPVA_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
// An antecedent implies the consequent in the same cycle.
`define FPVA_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`endif

>>> rtl/core/fpva_pkg.sv
// Package with widths, types and helpers for the filtered position estimator.
package fpva_pkg;
    localparam int AvgLog2 = 6;
    localparam int WinLen = 1 << AvgLog2;
    localparam int SumW = 32 + AvgLog2;
    localparam int NumW = 50;
    localparam logic signed [15:0] PosMin = -16'sd32768;
    localparam logic signed [15:0] PosMax = 16'sd32767;

    // Window selector for the shared boxcar datapath.
    typedef enum logic [1:0] {
        WIN_POS = 2'd0,
        WIN_VEL = 2'd1,
        WIN_ACC = 2'd2
    } win_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     load;      // capture input item
        logic     rd;        // read window entry
        logic     push;      // write window entry and update sum
        win_sel_t win;
        logic     div_start; // start divider
        logic     div_vel;   // 1: velocity quotient, 0: acceleration
        logic     commit_v;  // update last velocity
        logic     out_load;  // capture result
    } fpva_cmd_t;

    // Status from the datapath.
    typedef struct packed {
        logic zero_td;
        logic div_done;
    } fpva_stat_t;

    // Floor average of a window sum.
    function automatic logic signed [31:0] win_avg(input logic signed [SumW-1:0] s);
        logic signed [SumW-1:0] t;
        t = s >>> AvgLog2;
        return t[31:0];
    endfunction

    // Saturate a 50-bit quotient to signed 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [NumW-1:0] v);
        logic signed [31:0] r;
        if (v > $signed({{(NumW-32){1'b0}}, 32'h7fff_ffff}))
            r = 32'sh7fff_ffff;
        else if (v < $signed({{(NumW-32){1'b1}}, 32'h8000_0000}))
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction
endpackage

>>> rtl/core/fpva_div.sv
// Radix-2 signed divider, one quotient bit per cycle, truncating toward zero.
module fpva_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic signed [fpva_pkg::NumW-1:0] num,
    input  logic signed [31:0]               den,
    output logic                             done,
    output logic signed [fpva_pkg::NumW-1:0] quo
);
    import fpva_pkg::*;

    logic [NumW-1:0] q_reg, q_next;
    logic [32:0]     r_reg, r_next;
    logic [31:0]     d_reg, d_next;
    logic [5:0]      cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic            neg_reg, neg_next;
    logic            done_reg, done_next;
    logic [33:0]     trial;
    logic [NumW-1:0] anum;

    assign anum = num[NumW-1] ? NumW'(-num) : num;
    assign trial = {r_reg, q_reg[NumW-1]} - {2'b00, d_reg};

    // Restoring division step.
    always_comb
    begin
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        neg_next = neg_reg;
        done_next = 1'b0;
        if (start)
        begin
            q_next = anum;
            r_next = '0;
            d_next = den[31] ? 32'(-den) : den;
            neg_next = num[NumW-1] ^ den[31];
            cnt_next = 6'(NumW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[33])
            begin
                r_next = trial[32:0];
                q_next = {q_reg[NumW-2:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[31:0], q_reg[NumW-1]};
                q_next = {q_reg[NumW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
        neg_reg <= neg_next;
    end

    assign done = done_reg;
    assign quo = neg_reg ? NumW'(-q_reg) : q_reg;
endmodule

>>> rtl/core/fpva_datapath.sv
// Datapath: three boxcar windows in one memory, sums, divider and result register.
module fpva_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  fpva_pkg::fpva_cmd_t cmd,
    output fpva_pkg::fpva_stat_t stat,
    input  logic [63:0]         in_data,
    output logic [87:0]         out_data
);
    import fpva_pkg::*;

    // Window memory; rows never written read as zero through valid bits.
    logic [31:0]           mem [3*WinLen];
    logic [3*WinLen-1:0]   vld_reg;
    logic [31:0]           rd_reg;
    logic                  rdv_reg;
    logic signed [SumW-1:0] sum_reg [3];
    logic [AvgLog2-1:0]     slot_reg [3];
    logic signed [31:0]    samp_reg, lpos_reg, lvel_reg, pos_reg, vel_reg, wv;
    logic [31:0]           ptick_reg;
    logic signed [31:0]    td_reg;
    logic signed [NumW-1:0] quo, num;
    logic                  done;
    logic [7:0]            addr;
    logic signed [SumW-1:0] nsum;
    logic signed [31:0]    avg, acc_avg;
    logic signed [15:0]    clamp;

    assign addr = {cmd.win, slot_reg[cmd.win]};
    assign wv = (cmd.win == WIN_POS) ? samp_reg : sat32(quo);
    assign nsum = sum_reg[cmd.win] - SumW'($signed(rdv_reg ? rd_reg : 32'd0))
                  + SumW'(wv);
    assign avg = win_avg(nsum);
    assign acc_avg = win_avg(sum_reg[WIN_ACC]);
    assign num = cmd.div_vel ? (NumW'(pos_reg) - NumW'(lpos_reg)) <<< 16
                 : (NumW'(vel_reg) - NumW'(lvel_reg)) <<< 16;

    fpva_div u_div (
        .clk(clk), .rst_n(rst_n), .start(cmd.div_start), .num(num),
        .den(td_reg), .done(done), .quo(quo)
    );

    // Memory port.
    always_ff @(posedge clk)
    begin
        if (cmd.rd)
            rd_reg <= mem[addr];
        if (cmd.push)
            mem[addr] <= wv;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            rdv_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                sum_reg[i] <= '0;
                slot_reg[i] <= '0;
            end
            lpos_reg <= '0;
            lvel_reg <= '0;
            ptick_reg <= '0;
        end
        else
        begin
            if (cmd.rd)
                rdv_reg <= vld_reg[addr];
            if (cmd.load)
                ptick_reg <= in_data[63:32];
            if (cmd.push)
            begin
                vld_reg[addr] <= 1'b1;
                sum_reg[cmd.win] <= nsum;
                slot_reg[cmd.win] <= slot_reg[cmd.win] + 1'b1;
            end
            // Last position follows the result so the velocity step sees the prior one.
            if (cmd.out_load)
                lpos_reg <= pos_reg;
            if (cmd.commit_v)
                lvel_reg <= vel_reg;
        end
    end

    // Item capture and derived values.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            samp_reg <= in_data[31:0];
            td_reg <= in_data[63:32] - ptick_reg;
        end
        if (cmd.push && cmd.win == WIN_POS)
            pos_reg <= avg;
        if (cmd.push && cmd.win == WIN_VEL)
            vel_reg <= avg;
        if (cmd.out_load)
        begin
            out_data[15:0] <= clamp;
            out_data[47:16] <= stat.zero_td ? lvel_reg : vel_reg;
            out_data[79:48] <= acc_avg;
            out_data[80] <= stat.zero_td;
            out_data[87:81] <= '0;
        end
    end

    assign clamp = (pos_reg < 32'(PosMin)) ? PosMin :
                   (pos_reg > 32'(PosMax)) ? PosMax : pos_reg[15:0];
    assign stat.zero_td = (td_reg == 32'sd0);
    assign stat.div_done = done;
endmodule

>>> rtl/core/fpva_ctrl.sv
// Controller sequencing the window updates and divisions for one item.
module fpva_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output fpva_pkg::fpva_cmd_t  cmd,
    input  fpva_pkg::fpva_stat_t stat
);
    import fpva_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_PRD   = 10'b0000000010,
        S_PPUSH = 10'b0000000100,
        S_VDIV  = 10'b0000001000,
        S_VWAIT = 10'b0000010000,
        S_VPUSH = 10'b0000100000,
        S_ADIV  = 10'b0001000000,
        S_AWAIT = 10'b0010000000,
        S_APUSH = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    logic   ov_reg, ov_next;

    assign in_ready = (state_reg == S_IDLE) && !ov_reg;
    assign out_valid = ov_reg;

    always_comb
    begin
        state_next = state_reg;
        ov_next = ov_reg && !out_ready;
        cmd = '0;
        cmd.win = WIN_POS;
        case (state_reg)
            S_IDLE:
                if (in_valid && in_ready)
                begin
                    cmd.load = 1'b1;
                    state_next = S_PRD;
                end
            S_PRD:
            begin
                cmd.rd = 1'b1;
                state_next = S_PPUSH;
            end
            S_PPUSH:
            begin
                cmd.push = 1'b1;
                state_next = stat.zero_td ? S_OUT : S_VDIV;
            end
            S_VDIV:
            begin
                cmd.div_start = 1'b1;
                cmd.div_vel = 1'b1;
                cmd.win = WIN_VEL;
                cmd.rd = 1'b1;
                state_next = S_VWAIT;
            end
            S_VWAIT:
            begin
                cmd.win = WIN_VEL;
                if (stat.div_done)
                    state_next = S_VPUSH;
            end
            S_VPUSH:
            begin
                cmd.win = WIN_VEL;
                cmd.push = 1'b1;
                state_next = S_ADIV;
            end
            S_ADIV:
            begin
                cmd.div_start = 1'b1;
                cmd.win = WIN_ACC;
                cmd.rd = 1'b1;
                state_next = S_AWAIT;
            end
            S_AWAIT:
            begin
                cmd.win = WIN_ACC;
                if (stat.div_done)
                    state_next = S_APUSH;
            end
            S_APUSH:
            begin
                cmd.win = WIN_ACC;
                cmd.push = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                cmd.out_load = 1'b1;
                ov_next = 1'b1;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
        // Last velocity is committed with the result of a nonzero interval.
        cmd.commit_v = (state_reg == S_OUT) && !stat.zero_td;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg <= ov_next;
        end
    end
endmodule

>>> rtl/core/filtered_position_velocity_accel_top.sv
// Top level of the filtered position, velocity and acceleration estimator.
// One item at a time; the next item can be taken from the cycle after the result is taken.
// Reset is asynchronous, active low; windows, sums and history read as zero after it.
module filtered_position_velocity_accel_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // sample[31:0], tick_now[63:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata    // position_out, velocity, acceleration, zero_interval
);
    import fpva_pkg::*;

    fpva_cmd_t  cmd;
    fpva_stat_t stat;

    fpva_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(s_tvalid), .in_ready(s_tready),
        .out_valid(m_tvalid), .out_ready(m_tready), .cmd(cmd), .stat(stat)
    );

    fpva_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .in_data(s_tdata), .out_data(m_tdata)
    );
endmodule

>>> rtl/core/fpva_checker.sv
// Port checker for the estimator, bound to the top level.
`include "filtered_position_velocity_accel_top_macros.svh"
module fpva_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [87:0] m_tdata
);
    `FPVA_SAME(a_one_side, clk, rst_n, m_tvalid, !s_tready, "input taken while result waits")
    `FPVA_NEXT(a_busy, clk, rst_n, s_tvalid && s_tready, !s_tready, "two items taken back to back")
    `FPVA_NEXT(a_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped")
    `FPVA_SAME(a_pad, clk, rst_n, m_tvalid, m_tdata[87:81] == 7'd0, "padding nonzero")
endmodule

bind filtered_position_velocity_accel_top fpva_checker u_chk (
    .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
